FILE: hdl/sbda_pkg.sv
package sbda_pkg;

	// Default input width
	localparam int VALUE_BITS_DEF = 32;

	// ASCII codes
	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	// BCD digits needed for the largest magnitude, 2^(bits-1).
	// The constant sits slightly above log10(2), so the count never falls short.
	function automatic int num_digits(input int bits);
		return ((bits - 1) * 30103) / 100000 + 1;
	endfunction

endpackage

FILE: hdl/sbda_front.sv
module sbda_front #(
	parameter int VALUE_BITS = sbda_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [VALUE_BITS-1:0] value,
	output logic                  q_valid,
	input  logic                  q_ready,
	output logic                  q_neg,
	output logic [VALUE_BITS-1:0] q_mag
);
	import sbda_pkg::*;

	logic                  neg_q [2];
	logic [VALUE_BITS-1:0] mag_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            count_q;
	logic                  push;
	logic                  pop;
	logic                  neg_in;
	logic [VALUE_BITS-1:0] mag_in;

	// Classify sign and form the unsigned magnitude
	assign neg_in = value[VALUE_BITS-1];
	assign mag_in = neg_in ? (~value + VALUE_BITS'(1)) : value;

	assign s_tready = (count_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_valid && q_ready;
	assign q_neg    = neg_q[rd_ptr_q];
	assign q_mag    = mag_q[rd_ptr_q];

	// Store requests in the two-entry queue
	always_ff @(posedge clk) begin
		if (push) begin
			neg_q[wr_ptr_q] <= neg_in;
			mag_q[wr_ptr_q] <= mag_in;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)      count_q <= count_q + 2'd1;
			else if (!push && pop) count_q <= count_q - 2'd1;
		end
	end

endmodule

FILE: hdl/sbda_back.sv
module sbda_back #(
	parameter int VALUE_BITS = sbda_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  logic                  q_neg,
	input  logic [VALUE_BITS-1:0] q_mag,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [7:0]            m_tdata,
	output logic                  m_tlast
);
	import sbda_pkg::*;

	localparam int ND     = num_digits(VALUE_BITS);
	localparam int BCD_W  = ND * 4;
	localparam int BIT_W  = $clog2(VALUE_BITS + 1);
	localparam int DIG_W  = $clog2(ND + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	state_t                state_q;
	logic [VALUE_BITS-1:0] bin_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_adj;
	logic [BIT_W-1:0]      bit_cnt_q;
	logic [DIG_W-1:0]      dig_cnt_q;
	logic                  neg_q;
	logic                  started_q;
	logic                  m_tvalid_q;
	logic [7:0]            m_tdata_q;
	logic                  m_tlast_q;
	logic                  out_free;
	logic [3:0]            top_dig;
	logic                  last_dig;
	logic                  skip_zero;
	logic                  emit_sign;
	logic                  emit_digit;

	assign q_ready  = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign top_dig  = bcd_q[BCD_W-1 -: 4];
	assign last_dig = (dig_cnt_q == DIG_W'(1));
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// Decide whether this cycle skips a leading zero or emits a character
	assign skip_zero  = (top_dig == 4'd0) && !started_q && !last_dig;
	assign emit_sign  = (state_q == ST_SIGN) && neg_q && out_free;
	assign emit_digit = (state_q == ST_DIGIT) && !skip_zero && out_free;

	// Add three to every BCD digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < ND; i++) begin
			bcd_adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ?
				(bcd_q[i*4 +: 4] + 4'd3) : bcd_q[i*4 +: 4];
		end
	end

	// Sequence conversion and character output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			bin_q      <= '0;
			bcd_q      <= '0;
			bit_cnt_q  <= '0;
			dig_cnt_q  <= '0;
			neg_q      <= 1'b0;
			started_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tlast_q  <= 1'b0;
		end else begin
			// load the output register, or drop the output once taken
			if (emit_sign) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= CHAR_MINUS;
				m_tlast_q  <= 1'b0;
			end else if (emit_digit) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= CHAR_ZERO + {4'd0, top_dig};
				m_tlast_q  <= last_dig;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						bin_q     <= q_mag;
						neg_q     <= q_neg;
						bcd_q     <= '0;
						bit_cnt_q <= BIT_W'(VALUE_BITS);
						dig_cnt_q <= DIG_W'(ND);
						started_q <= 1'b0;
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bcd_q     <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
					bin_q     <= bin_q << 1;
					bit_cnt_q <= bit_cnt_q - BIT_W'(1);
					if (bit_cnt_q == BIT_W'(1)) state_q <= ST_SIGN;
				end
				ST_SIGN: begin
					if (!neg_q || emit_sign) begin
						state_q <= ST_DIGIT;
					end
				end
				ST_DIGIT: begin
					if (skip_zero) begin
						// skip a leading zero
						bcd_q     <= bcd_q << 4;
						dig_cnt_q <= dig_cnt_q - DIG_W'(1);
					end else if (emit_digit) begin
						started_q  <= 1'b1;
						bcd_q      <= bcd_q << 4;
						dig_cnt_q  <= dig_cnt_q - DIG_W'(1);
						if (last_dig) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: hdl/signed_binary_to_decimal_ascii_unit.sv
// Signed binary to decimal ASCII converter.
// Slave channel (s_*): one request per two's complement integer, taken on
// s_tvalid & s_tready. The value sits in the low VALUE_BITS of s_tdata.
// Master channel (m_*): one request per character, most significant first:
// an optional '-' and then the decimal digits without leading zeros; zero
// gives a single '0'. m_tlast marks the final character of each number.
// A two-entry queue sits behind the slave side, so up to two numbers are
// taken while an earlier one is still being converted or emitted.
// Per number: a load, shift-add-3 conversion of all VALUE_BITS input bits
// (one input bit per cycle), the sign step, then each BCD digit position
// in turn (ND = 10 at 32 bits), skipped leading zeros included. With the
// back end idle, the minus sign, if any, follows the conversion, and the
// first digit follows the sign step, delayed by each skipped leading zero.
// While m_tready is low the current character holds in the output register
// and the sign and digit steps stall; the queue keeps accepting until full.
// Reset (arst_n low) empties the queue and drops any conversion in flight.
module signed_binary_to_decimal_ascii_unit #(
	parameter int VALUE_BITS = sbda_pkg::VALUE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// bits: value[VALUE_BITS-1:0], zero pad up to a whole byte
	input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// bits: character[7:0]
	output logic [7:0]                           m_tdata,
	output logic                                 m_tlast
);
	import sbda_pkg::*;

	logic                  q_valid;
	logic                  q_ready;
	logic                  q_neg;
	logic [VALUE_BITS-1:0] q_mag;

	sbda_front #(.VALUE_BITS(VALUE_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.value    (s_tdata[VALUE_BITS-1:0]),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_neg    (q_neg),
		.q_mag    (q_mag)
	);

	sbda_back #(.VALUE_BITS(VALUE_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_neg    (q_neg),
		.q_mag    (q_mag),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
